[hw/rtl/cube_to_cuboid_remap_unit_defines.svh]
// Assertion macros for the cube to cuboid remapping unit.
// Included by the top level; the user must have clk and rst_n in scope.
`ifndef CUBE_TO_CUBOID_REMAP_UNIT_DEFINES_SVH
`define CUBE_TO_CUBOID_REMAP_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CCR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("remap unit check failed");

// Next-cycle implication, disabled during reset.
`define CCR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("remap unit check failed");

`endif

[hw/rtl/ccr_pkg.sv]
// Shared types, constants and arithmetic helpers for the remapping unit.
// No dependencies.
package ccr_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned BFRAC   = 16;
  localparam int unsigned ENTRY_W = BFRAC + 2;
  localparam int unsigned ROW_W   = 3 * ENTRY_W;
  localparam int unsigned LEN_W   = 31;
  localparam int unsigned RNG_W   = 5;
  localparam int unsigned RNGS_W  = 6 * RNG_W;
  localparam int unsigned X_W     = 37;
  localparam int unsigned PROD_W  = X_W + ENTRY_W;
  localparam int unsigned ACC_W   = PROD_W + 2;
  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [ROW_W-1:0]  BASIS_X_RST = 54'd65536;
  localparam logic [ROW_W-1:0]  BASIS_Y_RST = 54'd17179869184;
  localparam logic [ROW_W-1:0]  BASIS_Z_RST = 54'd4503599627370496;
  localparam logic [LEN_W-1:0]  LEN_RST     = 31'd65536;
  localparam logic [RNGS_W-1:0] RANGES_RST  = 30'd33587232;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASIS_X = 4'd0,
    REG_BASIS_Y = 4'd1,
    REG_BASIS_Z = 4'd2,
    REG_LEN_X   = 4'd3,
    REG_LEN_Y   = 4'd4,
    REG_LEN_Z   = 4'd5,
    REG_BOX     = 4'd6,
    REG_RANGES  = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;
    logic signed [31:0] out_vel_z;
    logic        [31:0] misses_so_far;
  } out_item_t;

  typedef struct packed {
    logic load_item;
    logic calc_x;
    logic mul_en;
    logic mul_vel;
    logic sum_pos;
    logic sum_vel;
    logic advance;
    logic finish_hit;
    logic finish_miss;
  } ctrl_cmd_t;

  typedef struct packed {
    logic empty_range;
    logic hit;
    logic last_copy;
    logic out_free;
  } ctrl_stat_t;

  function automatic logic signed [ENTRY_W-1:0] basis_entry(
    input logic [ROW_W-1:0] row, input int unsigned j);
    return $signed(row[j*ENTRY_W +: ENTRY_W]);
  endfunction

  // Floor shift by the basis fraction, then clamp to a signed coordinate.
  function automatic logic signed [COORD_W-1:0] proj_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] sh;
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    sh = acc >>> BFRAC;
    hi = ACC_W'($signed({1'b0, {(COORD_W-1){1'b1}}}));
    lo = ACC_W'($signed({1'b1, {(COORD_W-1){1'b0}}}));
    if (sh > hi) begin
      return hi[COORD_W-1:0];
    end else if (sh < lo) begin
      return lo[COORD_W-1:0];
    end
    return sh[COORD_W-1:0];
  endfunction

endpackage

[hw/rtl/ccr_stream_if.sv]
// Valid/ready stream interface used for both item channels.
// Payload type is a parameter; depends on nothing else.
interface ccr_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[hw/rtl/cube_to_cuboid_remap_unit.sv]
// Cube to cuboid remapping unit: one particle position and velocity per
// transaction in, one remapped result per transaction out. The unit tests
// one periodic copy offset at a time in steps (offset add, basis multiply,
// sum and clamp, bounds check), walking x outermost and z innermost, and
// stops at the first copy inside the cuboid. Items are taken one at a
// time; the result sits in an output register so the next item is taken
// while it waits. The user must write configuration only while the unit
// is idle; the unit itself does not enforce this.
// Depends on ccr_pkg, ccr_stream_if, ccr_ctrl, ccr_datapath and the defines header.
`include "cube_to_cuboid_remap_unit_defines.svh"

module cube_to_cuboid_remap_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [ccr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ccr_pkg::ROW_W-1:0]     cfg_wdata,
  ccr_stream_if.sink                    in_if,
  ccr_stream_if.source                  out_if
);

  ccr_pkg::ctrl_cmd_t  cmd;
  ccr_pkg::ctrl_stat_t stat;
  ccr_pkg::in_item_t   in_data;
  ccr_pkg::out_item_t  out_data;
  logic                in_ready;
  logic                out_valid;

  assign in_data      = in_if.data;
  assign in_if.ready  = in_ready;
  assign out_if.valid = out_valid;
  assign out_if.data  = out_data;

  ccr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ccr_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_if.ready),
    .out_data  (out_data)
  );

  `CCR_ASSERT_SAME(a_miss_zero_pos, out_valid && !out_data.found, out_data.out_pos_x == 32'sd0 && out_data.out_pos_y == 32'sd0 && out_data.out_pos_z == 32'sd0)
  `CCR_ASSERT_NEXT(a_busy_after_accept, in_if.valid && in_ready, !in_ready)
  `CCR_ASSERT_SAME(a_finish_needs_room, cmd.finish_hit || cmd.finish_miss, !out_valid || out_if.ready)

endmodule

[hw/rtl/ccr_ctrl.sv]
// Sequencing state machine for the remapping unit.
// Depends on ccr_pkg; drives ccr_datapath through command and status structs.
module ccr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ccr_pkg::ctrl_stat_t stat,
  output ccr_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CALCX, ST_MUL, ST_SUM, ST_CHK, ST_VMUL, ST_VSUM, ST_HIT, ST_MISS
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt = stat.empty_range ? ST_MISS : ST_CALCX;
        end
      end
      ST_CALCX: begin
        cmd.calc_x = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum_pos = 1'b1;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (stat.hit) begin
          state_nxt = ST_VMUL;
        end else if (stat.last_copy) begin
          state_nxt = ST_MISS;
        end else begin
          cmd.advance = 1'b1;
          state_nxt = ST_CALCX;
        end
      end
      ST_VMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_vel = 1'b1;
        state_nxt = ST_VSUM;
      end
      ST_VSUM: begin
        cmd.sum_vel = 1'b1;
        state_nxt = ST_HIT;
      end
      ST_HIT: begin
        if (stat.out_free) begin
          cmd.finish_hit = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_MISS: begin
        if (stat.out_free) begin
          cmd.finish_miss = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hw/rtl/ccr_datapath.sv]
// Configuration registers, copy offset counters, projection datapath and
// output register of the remapping unit. Depends on ccr_pkg.
module ccr_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [ccr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ccr_pkg::ROW_W-1:0]        cfg_wdata,
  input  ccr_pkg::in_item_t                in_data,
  input  ccr_pkg::ctrl_cmd_t               cmd,
  output ccr_pkg::ctrl_stat_t              stat,
  output logic                             out_valid,
  input  logic                             out_ready,
  output ccr_pkg::out_item_t               out_data
);

  logic [ccr_pkg::ROW_W-1:0]  basis_r [3];
  logic [ccr_pkg::LEN_W-1:0]  len_r [3];
  logic [ccr_pkg::LEN_W-1:0]  box_r;
  logic [ccr_pkg::RNGS_W-1:0] rng_r;

  logic signed [31:0] p_r [3];
  logic signed [31:0] v_r [3];
  logic signed [ccr_pkg::RNG_W-1:0] idx_r [3];
  logic signed [ccr_pkg::X_W-1:0] x_r [3];
  logic signed [ccr_pkg::PROD_W-1:0] prod_r [9];
  logic signed [31:0] r_r [3];
  logic signed [31:0] vr_r [3];
  logic [31:0] miss_r;
  ccr_pkg::out_item_t out_r;
  logic out_valid_r;

  logic signed [ccr_pkg::RNG_W-1:0] rb [3];
  logic signed [ccr_pkg::RNG_W-1:0] re [3];
  logic wrap [3];
  logic signed [ccr_pkg::X_W-1:0] mvec [3];
  logic signed [31:0] proj [3];
  logic in_box [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rb[k] = $signed(rng_r[2*k*ccr_pkg::RNG_W +: ccr_pkg::RNG_W]);
      re[k] = $signed(rng_r[(2*k+1)*ccr_pkg::RNG_W +: ccr_pkg::RNG_W]);
      wrap[k] = (($signed({idx_r[k][ccr_pkg::RNG_W-1], idx_r[k]}) + 6'sd1) >=
                 $signed({re[k][ccr_pkg::RNG_W-1], re[k]}));
      mvec[k] = cmd.mul_vel ? ccr_pkg::X_W'(v_r[k]) : x_r[k];
      proj[k] = ccr_pkg::proj_sat(ccr_pkg::ACC_W'(prod_r[3*k]) +
                                  ccr_pkg::ACC_W'(prod_r[3*k+1]) +
                                  ccr_pkg::ACC_W'(prod_r[3*k+2]));
      in_box[k] = !r_r[k][31] && (r_r[k] < $signed({1'b0, len_r[k]}));
    end
  end

  assign stat.empty_range = (rb[0] >= re[0]) || (rb[1] >= re[1]) || (rb[2] >= re[2]);
  assign stat.hit         = in_box[0] && in_box[1] && in_box[2];
  assign stat.last_copy   = wrap[0] && wrap[1] && wrap[2];
  assign stat.out_free    = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      basis_r[0] <= ccr_pkg::BASIS_X_RST;
      basis_r[1] <= ccr_pkg::BASIS_Y_RST;
      basis_r[2] <= ccr_pkg::BASIS_Z_RST;
      len_r[0]   <= ccr_pkg::LEN_RST;
      len_r[1]   <= ccr_pkg::LEN_RST;
      len_r[2]   <= ccr_pkg::LEN_RST;
      box_r      <= ccr_pkg::LEN_RST;
      rng_r      <= ccr_pkg::RANGES_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ccr_pkg::REG_BASIS_X: basis_r[0] <= cfg_wdata;
        ccr_pkg::REG_BASIS_Y: basis_r[1] <= cfg_wdata;
        ccr_pkg::REG_BASIS_Z: basis_r[2] <= cfg_wdata;
        ccr_pkg::REG_LEN_X:   len_r[0]   <= cfg_wdata[ccr_pkg::LEN_W-1:0];
        ccr_pkg::REG_LEN_Y:   len_r[1]   <= cfg_wdata[ccr_pkg::LEN_W-1:0];
        ccr_pkg::REG_LEN_Z:   len_r[2]   <= cfg_wdata[ccr_pkg::LEN_W-1:0];
        ccr_pkg::REG_BOX:     box_r      <= cfg_wdata[ccr_pkg::LEN_W-1:0];
        ccr_pkg::REG_RANGES:  rng_r      <= cfg_wdata[ccr_pkg::RNGS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      p_r[0] <= in_data.pos_x;
      p_r[1] <= in_data.pos_y;
      p_r[2] <= in_data.pos_z;
      v_r[0] <= in_data.vel_x;
      v_r[1] <= in_data.vel_y;
      v_r[2] <= in_data.vel_z;
      for (int k = 0; k < 3; k++) begin
        idx_r[k] <= rb[k];
      end
    end else if (cmd.advance) begin
      // The z offset runs fastest, then y, then x.
      if (!wrap[2]) begin
        idx_r[2] <= idx_r[2] + 5'sd1;
      end else begin
        idx_r[2] <= rb[2];
        if (!wrap[1]) begin
          idx_r[1] <= idx_r[1] + 5'sd1;
        end else begin
          idx_r[1] <= rb[1];
          idx_r[0] <= idx_r[0] + 5'sd1;
        end
      end
    end
    if (cmd.calc_x) begin
      for (int k = 0; k < 3; k++) begin
        x_r[k] <= ccr_pkg::X_W'(p_r[k]) +
                  ccr_pkg::X_W'(idx_r[k]) * ccr_pkg::X_W'($signed({1'b0, box_r}));
      end
    end
    if (cmd.mul_en) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          prod_r[3*k+j] <= ccr_pkg::PROD_W'(mvec[j]) *
                           ccr_pkg::PROD_W'(ccr_pkg::basis_entry(basis_r[k], j));
        end
      end
    end
    if (cmd.sum_pos) begin
      for (int k = 0; k < 3; k++) begin
        r_r[k] <= proj[k];
      end
    end
    if (cmd.sum_vel) begin
      for (int k = 0; k < 3; k++) begin
        vr_r[k] <= proj[k];
      end
    end
    if (cmd.finish_hit) begin
      out_r.found         <= 1'b1;
      out_r.out_pos_x     <= r_r[0];
      out_r.out_pos_y     <= r_r[1];
      out_r.out_pos_z     <= r_r[2];
      out_r.out_vel_x     <= vr_r[0];
      out_r.out_vel_y     <= vr_r[1];
      out_r.out_vel_z     <= vr_r[2];
      out_r.misses_so_far <= miss_r;
    end else if (cmd.finish_miss) begin
      out_r.found         <= 1'b0;
      out_r.out_pos_x     <= '0;
      out_r.out_pos_y     <= '0;
      out_r.out_pos_z     <= '0;
      out_r.out_vel_x     <= v_r[0];
      out_r.out_vel_y     <= v_r[1];
      out_r.out_vel_z     <= v_r[2];
      out_r.misses_so_far <= miss_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      miss_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish_miss) begin
        miss_r <= miss_r + 32'd1;
      end
      if (cmd.finish_hit || cmd.finish_miss) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[verif/cube_to_cuboid_remap_unit_tb.sv]
// Self-checking testbench for the cube to cuboid remapping unit.
// It needs ccr_pkg, ccr_stream_if and the unit itself. A scoreboard class
// predicts each remapped particle and checks results in arrival order.
`timescale 1ns / 100ps

import ccr_pkg::*;

class remap_scoreboard;
  logic [ROW_W-1:0] regs[8];
  logic [31:0]      miss_total;
  out_item_t        remap_q[$];
  int               errors;
  int               hits;
  int               misses;
  int               checked;

  function new();
    regs[REG_BASIS_X] = BASIS_X_RST;
    regs[REG_BASIS_Y] = BASIS_Y_RST;
    regs[REG_BASIS_Z] = BASIS_Z_RST;
    regs[REG_LEN_X]   = ROW_W'(LEN_RST);
    regs[REG_LEN_Y]   = ROW_W'(LEN_RST);
    regs[REG_LEN_Z]   = ROW_W'(LEN_RST);
    regs[REG_BOX]     = ROW_W'(LEN_RST);
    regs[REG_RANGES]  = ROW_W'(RANGES_RST);
    miss_total = '0;
  endfunction

  function void set_reg(int idx, logic [ROW_W-1:0] val);
    int w;
    if (idx > 7) return;
    w = (idx < 3) ? 54 : ((idx == 7) ? 30 : 31);
    regs[idx] = val & ((ROW_W'(1) << w) - 1);
  endfunction

  function longint dot_sat(longint a, longint b, longint c, logic [ROW_W-1:0] row);
    logic signed [17:0] e0, e1, e2;
    longint acc;
    e0 = row[17:0];
    e1 = row[35:18];
    e2 = row[53:36];
    acc = a * longint'(e0) + b * longint'(e1) + c * longint'(e2);
    acc = acc >>> 16;
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    return acc;
  endfunction

  function void note_input(in_item_t it);
    out_item_t r;
    logic signed [4:0] f[6];
    longint box, x, y, z, rx, ry, rz;
    longint len[3];
    bit hit;
    for (int k = 0; k < 6; k++) f[k] = regs[REG_RANGES][k*5 +: 5];
    box = longint'(regs[REG_BOX][30:0]);
    len[0] = longint'(regs[REG_LEN_X][30:0]);
    len[1] = longint'(regs[REG_LEN_Y][30:0]);
    len[2] = longint'(regs[REG_LEN_Z][30:0]);
    hit = 0;
    r = '0;
    for (int ix = f[0]; ix < f[1] && !hit; ix++) begin
      x = longint'(it.pos_x) + ix * box;
      for (int iy = f[2]; iy < f[3] && !hit; iy++) begin
        y = longint'(it.pos_y) + iy * box;
        for (int iz = f[4]; iz < f[5] && !hit; iz++) begin
          z = longint'(it.pos_z) + iz * box;
          rx = dot_sat(x, y, z, regs[REG_BASIS_X]);
          ry = dot_sat(x, y, z, regs[REG_BASIS_Y]);
          rz = dot_sat(x, y, z, regs[REG_BASIS_Z]);
          hit = rx >= 0 && rx < len[0] && ry >= 0 && ry < len[1] && rz >= 0 && rz < len[2];
        end
      end
    end
    if (hit) begin
      hits++;
      r.found = 1'b1;
      r.out_pos_x = rx[31:0];
      r.out_pos_y = ry[31:0];
      r.out_pos_z = rz[31:0];
      r.out_vel_x = 32'(dot_sat(it.vel_x, it.vel_y, it.vel_z, regs[REG_BASIS_X]));
      r.out_vel_y = 32'(dot_sat(it.vel_x, it.vel_y, it.vel_z, regs[REG_BASIS_Y]));
      r.out_vel_z = 32'(dot_sat(it.vel_x, it.vel_y, it.vel_z, regs[REG_BASIS_Z]));
    end else begin
      misses++;
      miss_total = miss_total + 1;
      r.out_vel_x = it.vel_x;
      r.out_vel_y = it.vel_y;
      r.out_vel_z = it.vel_z;
    end
    r.misses_so_far = miss_total;
    remap_q.push_back(r);
  endfunction

  task report(string what, logic [31:0] want, logic [31:0] got);
    errors++;
    $display("MISMATCH result %0d %s: expected %h got %h", checked, what, want, got);
  endtask

  task check_result(out_item_t got);
    out_item_t want;
    if (remap_q.size() == 0) begin
      report("unexpected transaction", 32'h0, 32'h0);
      return;
    end
    want = remap_q.pop_front();
    if (got.found !== want.found) report("found", want.found, got.found);
    if (got.out_pos_x !== want.out_pos_x) report("out_pos_x", want.out_pos_x, got.out_pos_x);
    if (got.out_pos_y !== want.out_pos_y) report("out_pos_y", want.out_pos_y, got.out_pos_y);
    if (got.out_pos_z !== want.out_pos_z) report("out_pos_z", want.out_pos_z, got.out_pos_z);
    if (got.out_vel_x !== want.out_vel_x) report("out_vel_x", want.out_vel_x, got.out_vel_x);
    if (got.out_vel_y !== want.out_vel_y) report("out_vel_y", want.out_vel_y, got.out_vel_y);
    if (got.out_vel_z !== want.out_vel_z) report("out_vel_z", want.out_vel_z, got.out_vel_z);
    if (got.misses_so_far !== want.misses_so_far)
      report("misses_so_far", want.misses_so_far, got.misses_so_far);
    checked++;
  endtask
endclass

module cube_to_cuboid_remap_unit_tb;
  localparam int LIMIT = 6000000;
  localparam longint ONE = 65536;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ROW_W-1:0] cfg_wdata;
  int cycles;
  int phases;
  bit calm;
  bit held_once;
  int hold_left;
  remap_scoreboard sb;

  ccr_stream_if #(.T(in_item_t)) in_ch();
  ccr_stream_if #(.T(out_item_t)) out_ch();

  cube_to_cuboid_remap_unit u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_if(in_ch.sink),
    .out_if(out_ch.source)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: checks each transaction and decides ready for the next edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
      if (!held_once && sb.hits + sb.misses > 150) begin
        held_once <= 1'b1;
        hold_left <= 400;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 31);
      end
    end
  end

  task send_item(in_item_t it);
    while (!calm && $urandom_range(99) < 31) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(it);
  endtask

  task drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.remap_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task write_reg(int idx, logic [ROW_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx[CFG_IDX_W-1:0];
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  function logic [29:0] pack_ranges(int bx, int ex, int by, int ey, int bz, int ez);
    return {5'(ez), 5'(bz), 5'(ey), 5'(by), 5'(ex), 5'(bx)};
  endfunction

  function logic [ROW_W-1:0] pack_row(longint a, longint b, longint c);
    return {18'(c), 18'(b), 18'(a)};
  endfunction

  function in_item_t make_item(longint span, bit noise);
    in_item_t it;
    longint s;
    s = (span > 64'd2147483647) ? 64'd2147483647 : span;
    if (noise || s < 2) begin
      it.pos_x = $urandom;
      it.pos_y = $urandom;
      it.pos_z = $urandom;
    end else begin
      it.pos_x = 32'(longint'($urandom_range(0, 32'(s))) - s / 2);
      it.pos_y = 32'(longint'($urandom_range(0, 32'(s))) - s / 2);
      it.pos_z = 32'(longint'($urandom_range(0, 32'(s))) - s / 2);
    end
    it.vel_x = $urandom;
    it.vel_y = $urandom;
    it.vel_z = $urandom;
    return it;
  endfunction

  // Picks a random basis, box, cuboid and small copy ranges, then sends 100 items.
  task random_setup();
    longint box;
    longint sgn[3];
    int perm;
    box = $urandom_range(1 << 12, 1 << 18);
    for (int k = 0; k < 3; k++) sgn[k] = $urandom_range(1) ? ONE : -ONE;
    perm = $urandom_range(3);
    case (perm)
      0: begin
        write_reg(REG_BASIS_X, pack_row(sgn[0], 0, 0));
        write_reg(REG_BASIS_Y, pack_row(0, sgn[1], 0));
        write_reg(REG_BASIS_Z, pack_row(0, 0, sgn[2]));
      end
      1: begin
        write_reg(REG_BASIS_X, pack_row(0, sgn[0], 0));
        write_reg(REG_BASIS_Y, pack_row(0, 0, sgn[1]));
        write_reg(REG_BASIS_Z, pack_row(sgn[2], 0, 0));
      end
      2: begin
        write_reg(REG_BASIS_X, pack_row(ONE / 2, ONE / 2, 0));
        write_reg(REG_BASIS_Y, pack_row(-ONE / 2, ONE / 2, ONE / 4));
        write_reg(REG_BASIS_Z, pack_row(0, -ONE / 4, ONE));
      end
      default: begin
        write_reg(REG_BASIS_X, {$urandom, $urandom});
        write_reg(REG_BASIS_Y, {$urandom, $urandom});
        write_reg(REG_BASIS_Z, {$urandom, $urandom});
      end
    endcase
    write_reg(REG_BOX, box);
    write_reg(REG_LEN_X, box * $urandom_range(1, 2) + $urandom_range(0, 255));
    write_reg(REG_LEN_Y, box * $urandom_range(1, 2) - $urandom_range(0, 255));
    write_reg(REG_LEN_Z, box);
    write_reg(REG_RANGES, pack_ranges(-$urandom_range(2), $urandom_range(1, 2),
                                      -$urandom_range(2), $urandom_range(1, 2),
                                      -$urandom_range(2), $urandom_range(1, 2)));
    for (int n = 0; n < 100; n++) send_item(make_item(box * 4, $urandom_range(99) < 12));
  endtask

  initial begin
    in_item_t it;
    clk = 1'b0;
    rst_n = 1'b0;
    cycles = 0;
    phases = 0;
    calm = 1'b0;
    held_once = 1'b0;
    hold_left = 0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset setup: identity basis, unit cube, one copy. Bounds and extremes.
    it = '0;
    send_item(it);
    it.pos_x = 32'h0000_FFFF; it.pos_y = 32'h0000_FFFF; it.pos_z = 32'h0000_FFFF;
    it.vel_x = 32'h7FFF_FFFF; it.vel_y = 32'h8000_0000; it.vel_z = 32'hFFFF_FFFF;
    send_item(it);
    it.pos_x = 32'h0001_0000;
    send_item(it);
    it.pos_x = 32'hFFFF_FFFF;
    send_item(it);
    it.pos_x = 32'h7FFF_FFFF; it.pos_y = 32'h8000_0000;
    send_item(it);
    drain();
    write_reg(REG_RANGES, pack_ranges(-1, 2, -1, 2, -1, 2));
    it = '0;
    it.pos_x = -32'sd32768; it.pos_y = 32'sd98304; it.pos_z = 32'sd1000;
    it.vel_x = 32'sd5; it.vel_y = -32'sd7; it.vel_z = 32'h7FFF_FFFF;
    send_item(it);
    it.pos_x = -32'sd200000;
    send_item(it);
    drain();
    // Empty range on one axis: every item is a miss.
    write_reg(REG_RANGES, pack_ranges(0, 1, 2, 2, 0, 1));
    it = '0;
    send_item(it);
    send_item(make_item(ONE, 0));
    drain();
    // Zero length with otherwise valid copies.
    write_reg(REG_RANGES, pack_ranges(0, 1, 0, 1, 0, 1));
    write_reg(REG_LEN_Y, 0);
    send_item(it);
    drain();
    // Writes to indexes past the last register must change nothing.
    write_reg(8, '1);
    write_reg(15, '1);
    write_reg(REG_LEN_Y, ONE);
    send_item(it);
    // Extreme registers: widest basis entries, largest box and lengths.
    drain();
    write_reg(REG_BASIS_X, pack_row(131071, -131072, 131071));
    write_reg(REG_BASIS_Y, pack_row(-131072, 131071, -131072));
    write_reg(REG_BASIS_Z, '1);
    write_reg(REG_BOX, 64'h7FFF_FFFF);
    write_reg(REG_LEN_X, 64'h7FFF_FFFF);
    write_reg(REG_LEN_Y, 64'h7FFF_FFFF);
    write_reg(REG_LEN_Z, 64'h7FFF_FFFF);
    write_reg(REG_RANGES, pack_ranges(-16, 15, 0, 1, -1, 1));
    for (int n = 0; n < 6; n++) send_item(make_item(0, 1));
    drain();
    // Widest ranges on every axis, identity basis: the longest walks.
    write_reg(REG_BASIS_X, BASIS_X_RST);
    write_reg(REG_BASIS_Y, BASIS_Y_RST);
    write_reg(REG_BASIS_Z, BASIS_Z_RST);
    write_reg(REG_BOX, 1);
    write_reg(REG_LEN_X, 1);
    write_reg(REG_LEN_Y, 1);
    write_reg(REG_LEN_Z, 1);
    write_reg(REG_RANGES, pack_ranges(-16, 15, -16, 15, -16, 15));
    it = '0;
    it.pos_x = 32'sd20; it.pos_y = -32'sd20; it.pos_z = 32'sd3;
    send_item(it);
    it.pos_x = 32'sd100;
    send_item(it);
    drain();

    for (int p = 0; p < 12; p++) begin
      calm = (p == 4);
      random_setup();
      phases++;
      if (p == 6) begin
        // Let the block run dry in the middle of a phase.
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.remap_q.size() != 0) @(posedge clk);
        send_item(make_item(ONE, 1));
      end
      drain();
    end

    calm = 1'b1;
    drain();
    repeat (50) @(posedge clk);
    while (sb.remap_q.size() != 0) begin
      sb.report("result never arrived", 32'h0, 32'h0);
      void'(sb.remap_q.pop_front());
    end
    $display("Checked %0d transactions over %0d random setups plus directed cases.",
             sb.checked, phases);
    $display("Predicted %0d remapped and %0d missed particles.", sb.hits, sb.misses);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/ccr_pkg.sv
hw/rtl/ccr_stream_if.sv
hw/rtl/ccr_ctrl.sv
hw/rtl/ccr_datapath.sv
hw/rtl/cube_to_cuboid_remap_unit.sv
verif/cube_to_cuboid_remap_unit_tb.sv
